// ----- hdl/rmf_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_pkg
// Shared constants and types for the 7x7 RGB median filter.
// ----------------------------------------------------------------------------
package rmf_pkg;

   localparam int MAX_WIDTH  = 1024;
   localparam int MAX_HEIGHT = 4096;
   localparam int WIN        = 7;
   localparam int HALO       = WIN / 2;
   localparam int TAPS       = WIN * WIN;
   localparam int MID        = TAPS / 2;
   localparam int NUM_BANKS  = 16;
   localparam int BANK_W     = $clog2(NUM_BANKS);
   localparam int COL_W      = $clog2(MAX_WIDTH);
   localparam int WID_W      = 11;
   localparam int HGT_W      = 13;
   localparam int ROW_W      = 13;
   localparam int K_W        = 11;
   localparam int LEAD_W     = 12;
   localparam int CNT_W      = 23;
   localparam int CH_W       = 8;
   localparam int PIX_W      = 3 * CH_W;
   localparam int IDX_W      = 8;
   localparam int GRP_W      = $clog2(WIN + 1);
   localparam int RANK_W     = $clog2(TAPS);
   // input may run this many rows ahead of the fetch row before banks collide
   localparam int AHEAD      = NUM_BANKS - HALO - 1;

   typedef enum logic [IDX_W-1:0] {
      REG_WIDTH  = 8'd0,
      REG_HEIGHT = 8'd1
   } csr_reg_type;

   typedef logic [PIX_W-1:0] pix_type;

   typedef struct packed {
      logic [ROW_W-1:0] row;
      logic             done;
   } eng_status_type;

   typedef struct packed {
      logic [CNT_W-1:0] granted;
      logic             restart;
   } ing_status_type;

endpackage

// ----- hdl/rmf_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module rmf_ram #(
   parameter  int WIDTH  = 24,
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ----- hdl/rmf_ingest.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_ingest
// Request side: pixel position, write into the row banks, result credits.
// ----------------------------------------------------------------------------
module rmf_ingest
   import rmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              cfg_restart,
   input  logic [WID_W-1:0]  eff_w,
   input  logic [HGT_W-1:0]  eff_h,
   input  logic              take,
   input  logic              action,
   input  eng_status_type    eng,
   output logic              ready,
   output logic              wr_en,
   output logic [BANK_W-1:0] wr_bank,
   output logic [COL_W-1:0]  wr_col,
   output ing_status_type    status
);

   logic [ROW_W-1:0]       in_row_ff, in_row_in;
   logic [COL_W-1:0]       in_col_ff, in_col_in;
   logic [LEAD_W-1:0]      lead_ff, lead_in;
   logic [CNT_W-1:0]       granted_ff, granted_in;
   logic                   complete_ff, complete_in;
   logic [CNT_W-1:0]       total_ff;
   logic [WID_W+HGT_W-1:0] area;
   logic                   full, hazard, step, restart;
   logic [LEAD_W-1:0]      lead_max;
   logic [WID_W-1:0]       col_next;
   logic [ROW_W:0]         row_limit;

   assign area      = {{HGT_W{1'b0}}, eff_w} * {{WID_W{1'b0}}, eff_h};
   assign full      = in_row_ff >= eff_h;
   assign row_limit = {1'b0, eng.row} + (ROW_W+1)'(AHEAD);
   assign hazard    = !full && ({1'b0, in_row_ff} > row_limit);
   assign ready     = !complete_ff && !hazard;
   assign restart   = cfg_restart || (complete_ff && eng.done);
   assign wr_en     = take && !action && !full;
   assign wr_bank   = in_row_ff[BANK_W-1:0];
   assign wr_col    = in_col_ff;
   assign step      = take && (full || !action);
   assign lead_max  = LEAD_W'(HALO) * LEAD_W'(eff_w) + LEAD_W'(HALO);
   assign col_next  = {1'b0, in_col_ff} + 1'b1;

   assign status.granted = granted_ff;
   assign status.restart = restart;

   always_comb begin
      in_row_in   = in_row_ff;
      in_col_in   = in_col_ff;
      lead_in     = lead_ff;
      granted_in  = granted_ff;
      complete_in = complete_ff;
      if (restart) begin
         in_row_in   = '0;
         in_col_in   = '0;
         lead_in     = '0;
         granted_in  = '0;
         complete_in = 1'b0;
      end else begin
         if (wr_en) begin
            if (col_next >= eff_w) begin
               in_col_in = '0;
               in_row_in = in_row_ff + 1'b1;
            end else begin
               in_col_in = col_next[COL_W-1:0];
            end
         end
         if (step) begin
            if (lead_ff < lead_max) begin
               lead_in = lead_ff + 1'b1;
            end else begin
               granted_in = granted_ff + 1'b1;
               // hold off the next frame until the last result is fetched
               if (granted_in == total_ff) begin
                  complete_in = 1'b1;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_row_ff   <= '0;
         in_col_ff   <= '0;
         lead_ff     <= '0;
         granted_ff  <= '0;
         complete_ff <= 1'b0;
      end else begin
         in_row_ff   <= in_row_in;
         in_col_ff   <= in_col_in;
         lead_ff     <= lead_in;
         granted_ff  <= granted_in;
         complete_ff <= complete_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff <= area[CNT_W-1:0];
   end

endmodule

// ----- hdl/rmf_fetch.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_fetch
// Column sequencer: while en holds and results are granted, reads from the
// row banks one clamped 7-pixel column per cycle, shifted into the 7x7 window.
// ----------------------------------------------------------------------------
module rmf_fetch
   import rmf_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        en,
   input  logic [WID_W-1:0]            eff_w,
   input  logic [HGT_W-1:0]            eff_h,
   input  ing_status_type              ing,
   input  pix_type                     rd_data [NUM_BANKS],
   output logic                        rd_en,
   output logic [COL_W-1:0]            rd_col,
   output eng_status_type              status,
   output logic [TAPS-1:0][PIX_W-1:0]  window,
   output logic                        win_valid,
   output logic                        win_last
);

   logic [ROW_W-1:0]  er_ff, er_in;
   logic [K_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]  base_ff, base_in;
   logic [K_W-1:0]    k_end, k_sh;
   logic [COL_W-1:0]  col;
   logic [CNT_W:0]    lhs, rhs;
   logic              done, go;
   logic [ROW_W:0]    row_t;
   logic [ROW_W:0]    row_c;
   logic [BANK_W-1:0] bsel_in [WIN];
   logic [BANK_W-1:0] bsel_ff [WIN];
   logic              d_valid_ff, d_emit_ff, d_last_ff;
   logic              w_valid_ff, w_last_ff;
   pix_type           win_ff [WIN][WIN];

   assign k_end = K_W'(eff_w) + K_W'(2 * HALO - 1);
   assign k_sh  = k_ff - K_W'(HALO);
   assign done  = er_ff == eff_h;

   // padded column position k maps to column clamp(k - HALO)
   always_comb begin
      if (k_ff < K_W'(HALO)) begin
         col = '0;
      end else if (k_sh >= eff_w) begin
         col = COL_W'(eff_w - 1'b1);
      end else begin
         col = k_sh[COL_W-1:0];
      end
   end

   // wait until the request side has granted enough results for this column
   always_comb begin
      if (k_ff < K_W'(2 * HALO)) begin
         lhs = {1'b0, ing.granted} + (CNT_W+1)'(HALO - 1);
         rhs = {1'b0, base_ff} + (CNT_W+1)'(col);
      end else begin
         lhs = {1'b0, ing.granted} + (CNT_W+1)'(2 * HALO - 1);
         rhs = {1'b0, base_ff} + (CNT_W+1)'(k_ff);
      end
   end

   // hold every read until the lead-in is over and the first result is granted
   assign go     = en && !done && (lhs >= rhs) && (ing.granted != '0);
   assign rd_en  = go;
   assign rd_col = col;

   assign status.row  = er_ff;
   assign status.done = done;

   always_comb begin
      row_t = '0;
      row_c = '0;
      for (int dy = 0; dy < WIN; dy++) begin
         row_t = {1'b0, er_ff} + (ROW_W+1)'(dy);
         if (row_t < (ROW_W+1)'(HALO)) begin
            row_c = '0;
         end else if (row_t - (ROW_W+1)'(HALO) >= {1'b0, eff_h}) begin
            row_c = {1'b0, eff_h} - 1'b1;
         end else begin
            row_c = row_t - (ROW_W+1)'(HALO);
         end
         bsel_in[dy] = row_c[BANK_W-1:0];
      end
   end

   always_comb begin
      er_in   = er_ff;
      k_in    = k_ff;
      base_in = base_ff;
      if (ing.restart) begin
         er_in   = '0;
         k_in    = '0;
         base_in = '0;
      end else if (go) begin
         if (k_ff == k_end) begin
            k_in    = '0;
            er_in   = er_ff + 1'b1;
            base_in = base_ff + CNT_W'(eff_w);
         end else begin
            k_in = k_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         er_ff      <= '0;
         k_ff       <= '0;
         base_ff    <= '0;
         d_valid_ff <= 1'b0;
         w_valid_ff <= 1'b0;
      end else begin
         er_ff   <= er_in;
         k_ff    <= k_in;
         base_ff <= base_in;
         if (en) begin
            d_valid_ff <= go;
            w_valid_ff <= d_valid_ff && d_emit_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (go) begin
         d_emit_ff <= k_ff >= K_W'(2 * HALO);
         d_last_ff <= (er_ff == eff_h - 1'b1) && (k_ff == k_end);
         for (int dy = 0; dy < WIN; dy++) begin
            bsel_ff[dy] <= bsel_in[dy];
         end
      end
      if (en && d_valid_ff) begin
         w_last_ff <= d_last_ff;
         for (int c = 0; c < WIN - 1; c++) begin
            for (int r = 0; r < WIN; r++) begin
               win_ff[c][r] <= win_ff[c+1][r];
            end
         end
         for (int r = 0; r < WIN; r++) begin
            win_ff[WIN-1][r] <= rd_data[bsel_ff[r]];
         end
      end
   end

   always_comb begin
      for (int c = 0; c < WIN; c++) begin
         for (int r = 0; r < WIN; r++) begin
            window[c*WIN+r] = win_ff[c][r];
         end
      end
   end

   assign win_valid = w_valid_ff;
   assign win_last  = w_last_ff;

endmodule

// ----- hdl/rmf_median.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmf_median
// Rank-based median of 49 values: compare, partial counts, rank match.
// ----------------------------------------------------------------------------
module rmf_median
   import rmf_pkg::*;
(
   input  logic                       clock,
   input  logic                       en,
   input  logic [TAPS-1:0][CH_W-1:0]  vals,
   output logic [CH_W-1:0]            med
);

   logic [TAPS-1:0][CH_W-1:0]         v1_ff, v2_ff, v3_ff;
   logic [TAPS-1:0][TAPS-1:0]         below_in, below_ff;
   logic [TAPS-1:0][WIN-1:0][GRP_W-1:0] part_in, part_ff;
   logic [TAPS-1:0]                   pick_in, pick_ff;
   logic [RANK_W-1:0]                 rank;

   // ties are broken by position so every rank is taken exactly once
   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int j = 0; j < TAPS; j++) begin
            if (j < i) begin
               below_in[i][j] = vals[j] <= vals[i];
            end else if (j > i) begin
               below_in[i][j] = vals[j] < vals[i];
            end else begin
               below_in[i][j] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < TAPS; i++) begin
         for (int g = 0; g < WIN; g++) begin
            part_in[i][g] = '0;
            for (int b = 0; b < WIN; b++) begin
               part_in[i][g] = part_in[i][g] + GRP_W'(below_ff[i][g*WIN+b]);
            end
         end
      end
   end

   always_comb begin
      rank = '0;
      for (int i = 0; i < TAPS; i++) begin
         rank = '0;
         for (int g = 0; g < WIN; g++) begin
            rank = rank + RANK_W'(part_ff[i][g]);
         end
         pick_in[i] = rank == RANK_W'(MID);
      end
   end

   always_comb begin
      med = '0;
      for (int i = 0; i < TAPS; i++) begin
         med = med | (v3_ff[i] & {CH_W{pick_ff[i]}});
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         v1_ff    <= vals;
         below_ff <= below_in;
         v2_ff    <= v1_ff;
         part_ff  <= part_in;
         v3_ff    <= v2_ff;
         pick_ff  <= pick_in;
      end
   end

endmodule

// ----- hdl/rgb_median_filter_7x7.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_median_filter_7x7
// Per-channel 7x7 median over a raster RGB stream with edge replication.
// Throughput: one result per cycle inside a row when granted and not stalled;
//   the column fetch from the 16 row banks walks 6 padding columns per row.
// Path: bank read, window register, median pipeline, output register to rsp.
// Reset: synchronous; counters clear, width 640 and height 480. Row banks are
//   not cleared; only pixels written in the current frame are read.
// ----------------------------------------------------------------------------
module rgb_median_filter_7x7
   import rmf_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [PIX_W-1:0]  req_tdata,   // chan0_in, chan1_in, chan2_in
   input  logic [0:0]        req_tuser,   // action
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic [PIX_W-1:0]  rsp_tdata,   // chan0_out, chan1_out, chan2_out
   output logic              rsp_tlast,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [HGT_W-1:0]  csr_data
);

   logic [WID_W-1:0]           width_ff;
   logic [HGT_W-1:0]           height_ff;
   logic [WID_W-1:0]           eff_w;
   logic [HGT_W-1:0]           eff_h;
   logic                       cfg_restart;
   logic                       take, en;
   logic                       wr_en, rd_en;
   logic [BANK_W-1:0]          wr_bank;
   logic [COL_W-1:0]           wr_col, rd_col;
   pix_type                    rd_data [NUM_BANKS];
   ing_status_type             ing;
   eng_status_type             eng;
   logic [TAPS-1:0][PIX_W-1:0] window;
   logic [TAPS-1:0][CH_W-1:0]  ch_vals [3];
   logic [CH_W-1:0]            med [3];
   logic                       win_valid, win_last;
   logic [2:0]                 vld_ff, last_ff;
   logic                       rsp_valid_ff;
   logic [PIX_W-1:0]           rsp_data_ff;
   logic                       rsp_last_ff;

   assign csr_ready = 1'b1;
   assign take      = req_tvalid && req_tready;
   assign en        = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (width_ff == '0) begin
         eff_w = WID_W'(1);
      end else if (width_ff > WID_W'(MAX_WIDTH)) begin
         eff_w = WID_W'(MAX_WIDTH);
      end else begin
         eff_w = width_ff;
      end
      if (height_ff == '0) begin
         eff_h = HGT_W'(1);
      end else if (height_ff > HGT_W'(MAX_HEIGHT)) begin
         eff_h = HGT_W'(MAX_HEIGHT);
      end else begin
         eff_h = height_ff;
      end
   end

   always_comb begin
      cfg_restart = 1'b0;
      if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_WIDTH:  cfg_restart = 1'b1;
            REG_HEIGHT: cfg_restart = 1'b1;
            default:    cfg_restart = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= WID_W'(640);
         height_ff <= HGT_W'(480);
      end else if (csr_valid) begin
         case (csr_reg_type'(csr_index))
            REG_WIDTH:  width_ff  <= csr_data[WID_W-1:0];
            REG_HEIGHT: height_ff <= csr_data;
            default:    ;
         endcase
      end
   end

   rmf_ingest u_ingest (
      .clock       (clock),
      .reset       (reset),
      .cfg_restart (cfg_restart),
      .eff_w       (eff_w),
      .eff_h       (eff_h),
      .take        (take),
      .action      (req_tuser[0]),
      .eng         (eng),
      .ready       (req_tready),
      .wr_en       (wr_en),
      .wr_bank     (wr_bank),
      .wr_col      (wr_col),
      .status      (ing)
   );

   // one bank per row modulo NUM_BANKS, addressed by column
   for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
      rmf_ram #(
         .WIDTH (PIX_W),
         .DEPTH (MAX_WIDTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en && (wr_bank == BANK_W'(b))),
         .wr_addr (wr_col),
         .wr_data (req_tdata),
         .rd_en   (rd_en),
         .rd_addr (rd_col),
         .rd_data (rd_data[b])
      );
   end

   rmf_fetch u_fetch (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .eff_w     (eff_w),
      .eff_h     (eff_h),
      .ing       (ing),
      .rd_data   (rd_data),
      .rd_en     (rd_en),
      .rd_col    (rd_col),
      .status    (eng),
      .window    (window),
      .win_valid (win_valid),
      .win_last  (win_last)
   );

   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         for (int t = 0; t < TAPS; t++) begin
            ch_vals[ch][t] = window[t][ch*CH_W +: CH_W];
         end
      end
   end

   for (genvar ch = 0; ch < 3; ch++) begin : g_med
      rmf_median u_median (
         .clock (clock),
         .en    (en),
         .vals  (ch_vals[ch]),
         .med   (med[ch])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         vld_ff       <= {vld_ff[1:0], win_valid};
         rsp_valid_ff <= vld_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         last_ff     <= {last_ff[1:0], win_last};
         rsp_last_ff <= last_ff[2];
         rsp_data_ff <= {med[2], med[1], med[0]};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule
